// ===== rtl/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

    localparam int LENGTH_WIDTH_DEF = 64;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int KIND_W   = 2;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [KIND_W-1:0]   kind_t;

    // Result kinds.
    localparam kind_t KIND_PAYLOAD     = 2'd0;
    localparam kind_t KIND_EMPTY_FRAME = 2'd1;
    localparam kind_t KIND_UNMASKED    = 2'd2;

    // Header fields of the first two header bytes.
    localparam byte_t MASK_BIT    = 8'h80;
    localparam byte_t LEN7_MASK   = 8'h7f;
    localparam byte_t OPCODE_MASK = 8'h0f;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

endpackage

`default_nettype wire

// ===== rtl/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Parses a received byte stream into frames and unmasks the payload bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                           Direction
//  --------  ------------------------------------------------  ---------
//  input     in_valid, in_ready, in_byte                        in
//  result    out_valid, out_ready, out_byte, frame_opcode,      out
//            last_of_frame, kind
//
//  One request is taken per cycle when not stalled; a result, if the byte
//  causes one, is shown in the cycle after the byte is taken. The parser
//  state updates at acceptance and the result sits in an output register, so
//  a new byte is taken while a result waits as long as that result leaves
//  in the same cycle. The critical path is the remaining-length decrement
//  and zero test. Reset returns the parser to the first header byte and
//  clears the halt state that an unmasked frame leaves behind.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top #(
    parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  wsdf_pkg::byte_t in_byte,
    output logic                  out_valid,
    input  wire                   out_ready,
    output wsdf_pkg::byte_t       out_byte,
    output wsdf_pkg::opcode_t     frame_opcode,
    output logic                  last_of_frame,
    output wsdf_pkg::kind_t       kind
);

    import wsdf_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_HALT    = 3'd5;

    typedef logic [LENGTH_WIDTH-1:0] len_t;

    logic [2:0]  phase_reg, phase_next;
    opcode_t     opcode_reg, opcode_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    len_t        rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_seen_reg, key_seen_next;
    logic [1:0]  mask_idx_reg, mask_idx_next;

    logic        out_valid_reg, out_valid_next;
    byte_t       out_byte_reg, out_byte_next;
    opcode_t     out_opcode_reg, out_opcode_next;
    logic        out_last_reg, out_last_next;
    kind_t       out_kind_reg, out_kind_next;

    logic        accept;
    logic        emit;
    logic [6:0]  len7;
    byte_t       key_byte;
    len_t        rem_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign len7     = 7'(in_byte & LEN7_MASK);
    assign rem_dec  = rem_reg - len_t'(1);

    always_comb
    begin
        unique case (mask_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        ext_left_next   = ext_left_reg;
        rem_next        = rem_reg;
        key_next        = key_reg;
        key_seen_next   = key_seen_reg;
        mask_idx_next   = mask_idx_reg;
        emit            = 1'b0;
        out_byte_next   = out_byte_reg;
        out_opcode_next = out_opcode_reg;
        out_last_next   = out_last_reg;
        out_kind_next   = out_kind_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = OPCODE_W'(in_byte & OPCODE_MASK);
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if ((in_byte & MASK_BIT) == '0)
                    begin
                        phase_next    = PH_HALT;
                        emit          = 1'b1;
                        out_byte_next = '0;
                        out_last_next = 1'b0;
                        out_kind_next = KIND_UNMASKED;
                    end
                    else
                    begin
                        key_seen_next = '0;
                        key_next      = '0;
                        if (len7 == LEN7_EXT16)
                        begin
                            ext_left_next = 4'd2;
                            rem_next      = '0;
                            phase_next    = PH_EXT;
                        end
                        else if (len7 == LEN7_EXT64)
                        begin
                            ext_left_next = 4'd8;
                            rem_next      = '0;
                            phase_next    = PH_EXT;
                        end
                        else
                        begin
                            ext_left_next = '0;
                            rem_next      = len_t'(len7);
                            phase_next    = PH_KEY;
                        end
                    end
                end
                PH_EXT:
                begin
                    // Big-endian: older bytes shift toward the top and drop out.
                    rem_next      = {rem_reg[LENGTH_WIDTH-BYTE_W-1:0], in_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_reg == 4'd1)
                    begin
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (key_seen_reg == 2'd3)
                    begin
                        key_seen_next = '0;
                        mask_idx_next = '0;
                        if (rem_reg == '0)
                        begin
                            phase_next    = PH_HDR0;
                            emit          = 1'b1;
                            out_byte_next = '0;
                            out_last_next = 1'b1;
                            out_kind_next = KIND_EMPTY_FRAME;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        key_seen_next = key_seen_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next      = rem_dec;
                    mask_idx_next = mask_idx_reg + 2'd1;
                    emit          = 1'b1;
                    out_byte_next = in_byte ^ key_byte;
                    out_last_next = (rem_dec == '0);
                    out_kind_next = KIND_PAYLOAD;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
            if (emit)
            begin
                out_opcode_next = opcode_next;
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= '0;
            ext_left_reg  <= '0;
            rem_reg       <= '0;
            key_reg       <= '0;
            key_seen_reg  <= '0;
            mask_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            ext_left_reg  <= ext_left_next;
            rem_reg       <= rem_next;
            key_reg       <= key_next;
            key_seen_reg  <= key_seen_next;
            mask_idx_reg  <= mask_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_opcode_reg <= out_opcode_next;
        out_last_reg   <= out_last_next;
        out_kind_reg   <= out_kind_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign frame_opcode  = out_opcode_reg;
    assign last_of_frame = out_last_reg;
    assign kind          = out_kind_reg;

endmodule

`default_nettype wire

// ===== dv/websocket_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_tb
// Streams masked frames of every length form into the deframer and checks
// each unmasked payload byte and frame event against a cycle-free predictor.
// The run ends with an unmasked frame that halts the parser.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_top_tb;

    import wsdf_pkg::*;

    localparam real   HALF_PERIOD = 6.0;
    localparam int    MAX_REPORTS = 10;
    localparam int    RANDOM_BYTES = 1200;
    localparam real   RUN_LIMIT_NS = 20_000_000.0;

    typedef enum logic [2:0] {
        PARSE_HDR0,
        PARSE_HDR1,
        PARSE_EXTLEN,
        PARSE_KEY,
        PARSE_PAYLOAD,
        PARSE_HALTED
    } parse_state_e;

    typedef enum int {
        LEN_FORM_SHORT,
        LEN_FORM_EXT16,
        LEN_FORM_EXT64
    } len_form_e;

    typedef struct packed {
        byte_t   data;
        opcode_t opcode;
        logic    last;
        kind_t   kind;
    } frame_event_t;

    class deframe_scoreboard;
        parse_state_e                  state;
        opcode_t                       opcode;
        logic [3:0]                    ext_left;
        logic [LENGTH_WIDTH_DEF-1:0]   bytes_left;
        logic [31:0]                   key;
        logic [1:0]                    keys_seen;
        logic [1:0]                    key_index;
        frame_event_t                  expected_events[$];
        int                            errors;

        function new();
            state      = PARSE_HDR0;
            opcode     = '0;
            ext_left   = '0;
            bytes_left = '0;
            key        = '0;
            keys_seen  = '0;
            key_index  = '0;
            errors     = 0;
        endfunction

        function void push_event(byte_t data, logic last, kind_t kind);
            frame_event_t ev;
            ev.data   = data;
            ev.opcode = opcode;
            ev.last   = last;
            ev.kind   = kind;
            expected_events.push_back(ev);
        endfunction

        // Advance the parser by one accepted byte.
        function void note_byte(byte_t b);
            byte_t key_byte;
            case (state)
                PARSE_HDR0:
                begin
                    opcode = OPCODE_W'(b & OPCODE_MASK);
                    state  = PARSE_HDR1;
                end
                PARSE_HDR1:
                begin
                    if ((b & MASK_BIT) == '0)
                    begin
                        state = PARSE_HALTED;
                        push_event('0, 1'b0, KIND_UNMASKED);
                    end
                    else
                    begin
                        keys_seen = '0;
                        key       = '0;
                        if (b[6:0] == LEN7_EXT16)
                        begin
                            ext_left   = 4'd2;
                            bytes_left = '0;
                            state      = PARSE_EXTLEN;
                        end
                        else if (b[6:0] == LEN7_EXT64)
                        begin
                            ext_left   = 4'd8;
                            bytes_left = '0;
                            state      = PARSE_EXTLEN;
                        end
                        else
                        begin
                            ext_left   = '0;
                            bytes_left = LENGTH_WIDTH_DEF'(b & LEN7_MASK);
                            state      = PARSE_KEY;
                        end
                    end
                end
                PARSE_EXTLEN:
                begin
                    bytes_left = (bytes_left << 8) | LENGTH_WIDTH_DEF'(b);
                    ext_left   = ext_left - 4'd1;
                    if (ext_left == '0)
                        state = PARSE_KEY;
                end
                PARSE_KEY:
                begin
                    key = {key[23:0], b};
                    if (keys_seen == 2'd3)
                    begin
                        keys_seen = '0;
                        key_index = '0;
                        if (bytes_left == '0)
                        begin
                            state = PARSE_HDR0;
                            push_event('0, 1'b1, KIND_EMPTY_FRAME);
                        end
                        else
                            state = PARSE_PAYLOAD;
                    end
                    else
                        keys_seen = keys_seen + 2'd1;
                end
                PARSE_PAYLOAD:
                begin
                    key_byte   = key[(3 - key_index) * 8 +: 8];
                    bytes_left = bytes_left - LENGTH_WIDTH_DEF'(1);
                    key_index  = key_index + 2'd1;
                    if (bytes_left == '0)
                        state = PARSE_HDR0;
                    push_event(b ^ key_byte, bytes_left == '0, KIND_PAYLOAD);
                end
                default:
                    state = PARSE_HALTED;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void check_result(frame_event_t got);
            frame_event_t want;
            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected result byte=%02h op=%0h last=%0b kind=%0d",
                                 got.data, got.opcode, got.last, got.kind));
                return;
            end
            want = expected_events.pop_front();
            if (got.data !== want.data)
                report($sformatf("out_byte expected %02h got %02h", want.data, got.data));
            if (got.opcode !== want.opcode)
                report($sformatf("frame_opcode expected %0h got %0h",
                                 want.opcode, got.opcode));
            if (got.last !== want.last)
                report($sformatf("last_of_frame expected %0b got %0b",
                                 want.last, got.last));
            if (got.kind !== want.kind)
                report($sformatf("kind expected %0d got %0d", want.kind, got.kind));
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    byte_t   in_byte;
    logic    out_valid;
    logic    out_ready;
    byte_t   out_byte;
    opcode_t frame_opcode;
    logic    last_of_frame;
    kind_t   kind;

    deframe_scoreboard sb = new();
    int  bytes_sent;
    bit  no_stalls;
    int  ready_hold;

    websocket_frame_deframer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .frame_opcode  (frame_opcode),
        .last_of_frame (last_of_frame),
        .kind          (kind)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Results are checked before the byte of the same edge is noted; a byte
    // never causes a result at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({out_byte, frame_opcode, last_of_frame, kind});
            if (in_valid && in_ready)
                sb.note_byte(in_byte);
        end
    end

    // Result side back-pressure: runs of ready, short stalls and rare long ones.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  = 1'b0;
            ready_hold = 0;
        end
        else if (no_stalls)
        begin
            out_ready  = 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold == 0)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                out_ready  = 1'b1;
                ready_hold = $urandom_range(1, 16);
            end
            else
            begin
                out_ready  = 1'b0;
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end
        else
            ready_hold = ready_hold - 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stalls || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input byte_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input opcode_t op, input int unsigned len,
                              input len_form_e form, input logic [31:0] key);
        logic [63:0] len64;
        logic [3:0]  flags;
        len64 = 64'(len);
        flags = 4'($urandom_range(0, 15));
        send_byte({flags, op});
        case (form)
            LEN_FORM_SHORT:
                send_byte(MASK_BIT | byte_t'(len));
            LEN_FORM_EXT16:
            begin
                send_byte(MASK_BIT | {1'b0, LEN7_EXT16});
                send_byte(len64[15:8]);
                send_byte(len64[7:0]);
            end
            default:
            begin
                send_byte(MASK_BIT | {1'b0, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len64[i * 8 +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(key[i * 8 +: 8]);
        for (int unsigned i = 0; i < len; i++)
            send_byte(byte_t'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame();
        int          pick;
        int unsigned len;
        len_form_e   form;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            form = LEN_FORM_SHORT;
            len  = $urandom_range(0, 12);
        end
        else if (pick < 70)
        begin
            form = LEN_FORM_SHORT;
            len  = $urandom_range(13, 125);
        end
        else if (pick < 87)
        begin
            form = LEN_FORM_EXT16;
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                                : $urandom_range(0, 20);
        end
        else
        begin
            form = LEN_FORM_EXT64;
            len  = $urandom_range(0, 40);
        end
        send_frame(opcode_t'($urandom_range(0, 15)), len, form, $urandom);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = '0;
        no_stalls  = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: empty frame, one-byte frame with an all-ones key,
        // key wrap over five bytes, empty frame behind a 16-bit length, and a
        // 64-bit length form.
        send_frame(4'h0, 0, LEN_FORM_SHORT, 32'h0000_0000);
        send_frame(4'hf, 1, LEN_FORM_SHORT, 32'hffff_ffff);
        send_frame(4'h1, 5, LEN_FORM_SHORT, 32'h0180_7ffe);
        send_frame(4'h9, 0, LEN_FORM_EXT16, 32'h5aa5_c33c);
        send_frame(4'ha, 2, LEN_FORM_EXT64, 32'h1234_abcd);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            no_stalls = ($urandom_range(0, 4) == 0);
            send_random_frame();
        end
        no_stalls = 1'b0;

        // An unmasked frame halts the parser; the bytes after it are dropped.
        send_byte({4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
        send_byte(byte_t'($urandom_range(0, 127)));
        repeat (3) send_byte(byte_t'($urandom_range(0, 255)));
        in_valid = 1'b0;

        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.expected_events.size() == 0)
            $display("websocket_frame_deframer_top verification clean");
        else
            $display("websocket_frame_deframer_top verification failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("websocket_frame_deframer_top verification failed");
        $finish;
    end

endmodule
